[design/ttqd_pkg.sv]
// Shared types, constants and codes for the timed task queue dispatcher.
package ttqd_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int RESULT_CAP = 16;
    localparam int IDX_W      = $clog2(MAX_TASKS);
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int CAP_W      = $clog2(RESULT_CAP + 1);

    localparam int MODE_W    = 2;
    localparam int ID_W      = 8;
    localparam int DELAY_W   = 31;
    localparam int TIME_W    = 32;
    localparam int LIMIT_W   = 16;
    localparam int KIND_W    = 3;
    localparam int MATCH_W   = 5;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd3;

    localparam logic [KIND_W-1:0] KIND_DISPATCH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXISTS    = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] period;
        logic              marked;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REMOVE,
        S_COUNT,
        S_CHECK,
        S_SEARCH,
        S_SHIFT,
        S_RESP,
        S_TICK,
        S_FLUSH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REMOVE_STEP,
        OP_REMOVE_END,
        OP_COUNT_STEP,
        OP_MARK_FULL,
        OP_SEARCH_INIT,
        OP_SEARCH_STEP,
        OP_SHIFT_STEP,
        OP_INSERT,
        OP_RESP,
        OP_TICK_STEP,
        OP_TICK_END,
        OP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic              rd_end;
        logic              full;
        logic              search_hit;
        logic              shift_done;
        logic              tick_due;
        logic              pend_valid;
        logic              out_free;
        logic [MODE_W-1:0] mode;
    } dp_status_t;

endpackage

[design/timed_task_queue_dispatcher_top.sv]
// Timed task queue dispatcher: due-ordered table of up to 16 timed tasks.
// One request is worked at a time; each walk reads one table slot per cycle,
// except that a tick walk holds while a dispatch result cannot be handed to the
// output register. Count and remove walk the stored tasks; a schedule runs an
// ordered search, a shift to open the slot and an insert, after a removal walk
// when once_flag is set; a full table gets a full result. The last result of
// each request carries tlast; a tick with nothing due returns no transfer.
module timed_task_queue_dispatcher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] task_id, [38:8] delay, [39] once_flag, [40] repeat_flag, [41] priority_flag
    input  logic [47:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_task_id, [12:8] match_count, [13] late_error, [45:14] late_excess
    output logic [47:0] m_axis_tdata,
    // [2:0] kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import ttqd_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [MATCH_W-1:0] match_count;
    logic               late_error;
    logic [TIME_W-1:0]  late_excess;
    logic [ID_W-1:0]    out_task_id;

    ttqd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_once  (s_axis_tdata[39]),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ttqd_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_mode         (s_axis_tuser),
        .in_task_id      (s_axis_tdata[7:0]),
        .in_delay        (s_axis_tdata[38:8]),
        .in_repeat       (s_axis_tdata[40]),
        .in_priority     (s_axis_tdata[41]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_kind        (m_axis_tuser),
        .out_task_id     (out_task_id),
        .out_match_count (match_count),
        .out_late_error  (late_error),
        .out_late_excess (late_excess),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, late_excess, late_error, match_count, out_task_id};

    logic [5:0] unused_in;
    assign unused_in = s_axis_tdata[47:42];

endmodule

[design/ttqd_ctrl.sv]
// Sequencer for the task table walks: remove, count, schedule and tick.
module ttqd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_once,
    input  logic [ttqd_pkg::MODE_W-1:0] in_mode,
    output logic                  in_ready,
    input  ttqd_pkg::dp_status_t  status,
    output ttqd_pkg::dp_cmd_t     cmd
);
    import ttqd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_mode)
                        MODE_SCHEDULE: state_next = in_once ? S_REMOVE : S_CHECK;
                        MODE_REMOVE:   state_next = S_REMOVE;
                        MODE_COUNT:    state_next = S_COUNT;
                        default:       state_next = S_TICK;
                    endcase
                end
            end
            S_REMOVE:
            begin
                if (status.rd_end)
                begin
                    state_next = (status.mode == MODE_SCHEDULE) ? S_CHECK : S_RESP;
                end
            end
            S_COUNT:
            begin
                if (status.rd_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_CHECK:
            begin
                state_next = status.full ? S_RESP : S_SEARCH;
            end
            S_SEARCH:
            begin
                if (status.rd_end || status.search_hit)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (status.shift_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (status.rd_end)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_REMOVE:
            begin
                cmd.op = status.rd_end ? OP_REMOVE_END : OP_REMOVE_STEP;
            end
            S_COUNT:
            begin
                if (!status.rd_end)
                begin
                    cmd.op = OP_COUNT_STEP;
                end
            end
            S_CHECK:
            begin
                cmd.op = status.full ? OP_MARK_FULL : OP_SEARCH_INIT;
            end
            S_SEARCH:
            begin
                if (!status.rd_end)
                begin
                    cmd.op = OP_SEARCH_STEP;
                end
            end
            S_SHIFT:
            begin
                cmd.op = status.shift_done ? OP_INSERT : OP_SHIFT_STEP;
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_RESP;
                end
            end
            S_TICK:
            begin
                if (status.rd_end)
                begin
                    cmd.op = OP_TICK_END;
                end
                // hold while a dispatch would push the pending result into a busy output
                else if (!(status.tick_due && status.pend_valid && !status.out_free))
                begin
                    cmd.op = OP_TICK_STEP;
                end
            end
            S_FLUSH:
            begin
                if (status.pend_valid && status.out_free)
                begin
                    cmd.op = OP_FLUSH;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

[design/ttqd_dp.sv]
// Task table, time base, walk pointers and result registers.
module ttqd_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ttqd_pkg::dp_cmd_t                 cmd,
    output ttqd_pkg::dp_status_t              status,
    input  logic [ttqd_pkg::MODE_W-1:0]       in_mode,
    input  logic [ttqd_pkg::ID_W-1:0]         in_task_id,
    input  logic [ttqd_pkg::DELAY_W-1:0]      in_delay,
    input  logic                              in_repeat,
    input  logic                              in_priority,
    input  logic                              cfg_wr_en,
    input  logic [ttqd_pkg::LIMIT_W-1:0]      cfg_wr_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ttqd_pkg::KIND_W-1:0]       out_kind,
    output logic [ttqd_pkg::ID_W-1:0]         out_task_id,
    output logic [ttqd_pkg::MATCH_W-1:0]      out_match_count,
    output logic                              out_late_error,
    output logic [ttqd_pkg::TIME_W-1:0]       out_late_excess,
    output logic                              out_last
);
    import ttqd_pkg::*;

    entry_t               tbl_reg [MAX_TASKS];
    logic [TIME_W-1:0]    time_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     wr_ptr_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [MATCH_W-1:0]   match_reg;
    logic [CAP_W-1:0]     disp_cnt_reg;
    logic                 full_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [ID_W-1:0]      id_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic                 repeat_reg;
    logic                 prio_reg;
    logic [TIME_W-1:0]    due_new_reg;

    logic                 pend_valid_reg;
    logic [ID_W-1:0]      pend_id_reg;
    logic                 pend_lerr_reg;
    logic [TIME_W-1:0]    pend_excess_reg;

    logic                 out_valid_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [MATCH_W-1:0]   out_match_reg;
    logic                 out_lerr_reg;
    logic [TIME_W-1:0]    out_excess_reg;
    logic                 out_last_reg;

    logic [CNT_W-1:0]     rd_sel;
    entry_t               ent;
    logic                 id_hit;
    logic [TIME_W-1:0]    due_bump;
    logic                 search_hit;
    logic [TIME_W-1:0]    late;
    logic                 tick_due;
    logic                 late_err;
    logic [TIME_W-1:0]    excess;
    entry_t               ent_upd;
    logic                 keep;
    logic                 out_free;
    logic [KIND_W-1:0]    resp_kind;
    logic                 push_pend;
    logic                 out_load;

    // shifting reads the slot below the write pointer; every other walk reads at rd_ptr
    assign rd_sel = (cmd.op == OP_SHIFT_STEP) ? (wr_ptr_reg - CNT_W'(1)) : rd_ptr_reg;
    assign ent    = tbl_reg[rd_sel[IDX_W-1:0]];
    assign id_hit = (ent.id == id_reg);

    assign due_bump   = (!prio_reg && (ent.due == due_new_reg)) ? (due_new_reg + TIME_W'(1))
                                                                : due_new_reg;
    assign search_hit = (ent.due > due_bump);

    assign late     = time_reg - ent.due;
    assign tick_due = !late[TIME_W-1] && (disp_cnt_reg < CAP_W'(RESULT_CAP));
    assign late_err = (late > {{(TIME_W-LIMIT_W){1'b0}}, limit_reg}) && !ent.marked;
    assign excess   = late - {{(TIME_W-LIMIT_W){1'b0}}, limit_reg};
    assign keep     = !tick_due || (ent.period != '0);

    always_comb
    begin
        ent_upd = ent;
        if (tick_due)
        begin
            ent_upd.marked = ent.marked | late_err;
            ent_upd.due    = ent.due + ent.period;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign push_pend = (cmd.op == OP_TICK_STEP) && tick_due && pend_valid_reg;
    assign out_load  = (cmd.op == OP_RESP) || (cmd.op == OP_FLUSH) || push_pend;

    always_comb
    begin
        case (mode_reg)
            MODE_SCHEDULE: resp_kind = full_reg ? KIND_FULL : KIND_SCHEDULED;
            MODE_REMOVE:   resp_kind = KIND_REMOVED;
            MODE_COUNT:    resp_kind = KIND_EXISTS;
            default:       resp_kind = KIND_DISPATCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            limit_reg      <= LIMIT_RESET;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            pos_reg        <= '0;
            match_reg      <= '0;
            disp_cnt_reg   <= '0;
            full_reg       <= 1'b0;
            mode_reg       <= MODE_SCHEDULE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    mode_reg     <= in_mode;
                    rd_ptr_reg   <= '0;
                    wr_ptr_reg   <= '0;
                    match_reg    <= '0;
                    disp_cnt_reg <= '0;
                    full_reg     <= 1'b0;
                    if (in_mode == MODE_TICK)
                    begin
                        time_reg <= time_reg + TIME_W'(1);
                    end
                end
                OP_REMOVE_STEP:
                begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    if (id_hit)
                    begin
                        match_reg <= match_reg + MATCH_W'(1);
                    end
                    else
                    begin
                        wr_ptr_reg <= wr_ptr_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE_END:
                begin
                    count_reg  <= wr_ptr_reg;
                    rd_ptr_reg <= '0;
                end
                OP_COUNT_STEP:
                begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    if (id_hit)
                    begin
                        match_reg <= match_reg + MATCH_W'(1);
                    end
                end
                OP_MARK_FULL:
                begin
                    full_reg <= 1'b1;
                end
                OP_SEARCH_INIT:
                begin
                    rd_ptr_reg <= '0;
                    wr_ptr_reg <= count_reg;
                    pos_reg    <= count_reg;
                end
                OP_SEARCH_STEP:
                begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    if (search_hit)
                    begin
                        pos_reg <= rd_ptr_reg;
                    end
                end
                OP_SHIFT_STEP:
                begin
                    wr_ptr_reg <= wr_ptr_reg - CNT_W'(1);
                end
                OP_INSERT:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                OP_TICK_STEP:
                begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    if (keep)
                    begin
                        wr_ptr_reg <= wr_ptr_reg + CNT_W'(1);
                    end
                    if (tick_due)
                    begin
                        pend_valid_reg <= 1'b1;
                        disp_cnt_reg   <= disp_cnt_reg + CAP_W'(1);
                    end
                end
                OP_TICK_END:
                begin
                    count_reg <= wr_ptr_reg;
                end
                OP_FLUSH:
                begin
                    pend_valid_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // table, request fields and result payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                id_reg     <= in_task_id;
                delay_reg  <= in_delay;
                repeat_reg <= in_repeat;
                prio_reg   <= in_priority;
            end
            OP_REMOVE_STEP:
            begin
                if (!id_hit)
                begin
                    tbl_reg[wr_ptr_reg[IDX_W-1:0]] <= ent;
                end
            end
            OP_SEARCH_INIT:
            begin
                due_new_reg <= time_reg + {1'b0, delay_reg};
            end
            OP_SEARCH_STEP:
            begin
                due_new_reg <= due_bump;
            end
            OP_SHIFT_STEP:
            begin
                tbl_reg[wr_ptr_reg[IDX_W-1:0]] <= ent;
            end
            OP_INSERT:
            begin
                tbl_reg[pos_reg[IDX_W-1:0]].id     <= id_reg;
                tbl_reg[pos_reg[IDX_W-1:0]].due    <= due_new_reg;
                tbl_reg[pos_reg[IDX_W-1:0]].period <= repeat_reg ? {1'b0, delay_reg} : '0;
                tbl_reg[pos_reg[IDX_W-1:0]].marked <= 1'b0;
            end
            OP_RESP:
            begin
                out_kind_reg   <= resp_kind;
                out_id_reg     <= id_reg;
                out_match_reg  <= (mode_reg == MODE_SCHEDULE) ? '0 : match_reg;
                out_lerr_reg   <= 1'b0;
                out_excess_reg <= '0;
                out_last_reg   <= 1'b1;
            end
            OP_TICK_STEP:
            begin
                if (keep)
                begin
                    tbl_reg[wr_ptr_reg[IDX_W-1:0]] <= ent_upd;
                end
                if (tick_due)
                begin
                    pend_id_reg     <= ent.id;
                    pend_lerr_reg   <= late_err;
                    pend_excess_reg <= late_err ? excess : '0;
                end
                if (push_pend)
                begin
                    out_kind_reg   <= KIND_DISPATCH;
                    out_id_reg     <= pend_id_reg;
                    out_match_reg  <= '0;
                    out_lerr_reg   <= pend_lerr_reg;
                    out_excess_reg <= pend_excess_reg;
                    out_last_reg   <= 1'b0;
                end
            end
            OP_FLUSH:
            begin
                out_kind_reg   <= KIND_DISPATCH;
                out_id_reg     <= pend_id_reg;
                out_match_reg  <= '0;
                out_lerr_reg   <= pend_lerr_reg;
                out_excess_reg <= pend_excess_reg;
                out_last_reg   <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign status.rd_end     = (rd_ptr_reg == count_reg);
    assign status.full       = (count_reg == CNT_W'(MAX_TASKS));
    assign status.search_hit = search_hit;
    assign status.shift_done = (wr_ptr_reg == pos_reg);
    assign status.tick_due   = tick_due;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;
    assign status.mode       = mode_reg;

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_task_id     = out_id_reg;
    assign out_match_count = out_match_reg;
    assign out_late_error  = out_lerr_reg;
    assign out_late_excess = out_excess_reg;
    assign out_last        = out_last_reg;

endmodule
